// ===== src/fed_pkg.sv =====
// Shared types and constants for the flight event detector.
package fed_pkg;

	localparam int ALT_W      = 20;
	localparam int TIME_W     = 32;
	localparam int FLAGS_W    = 7;
	localparam int COUNT_W    = 8;
	localparam int MARGIN_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// status_flags bit positions
	localparam int BIT_LAUNCH  = 0;
	localparam int BIT_APOGEE  = 1;
	localparam int BIT_GPS     = 2;
	localparam int BIT_BARO    = 3;
	localparam int BIT_STORAGE = 5;
	localparam int BIT_STALE   = 6;

	localparam logic [MARGIN_W-1:0] RST_LAUNCH_GAIN    = 16'd100;
	localparam logic [COUNT_W-1:0]  RST_LAUNCH_CONFIRM = 8'd3;
	localparam logic [MARGIN_W-1:0] RST_APOGEE_DROP    = 16'd50;
	localparam logic [MARGIN_W-1:0] RST_STALE_TIMEOUT  = 16'd3000;
	localparam logic [COUNT_W-1:0]  RST_BASELINE_COUNT = 8'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAUNCH_GAIN    = 3'd0,
		CFG_LAUNCH_CONFIRM = 3'd1,
		CFG_APOGEE_DROP    = 3'd2,
		CFG_STALE_TIMEOUT  = 3'd3,
		CFG_BASELINE_COUNT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] launch_gain_dm;
		logic [COUNT_W-1:0]  confirm_runs;
		logic [MARGIN_W-1:0] apogee_drop_dm;
		logic [MARGIN_W-1:0] stale_timeout_ms;
		logic [COUNT_W-1:0]  baseline_sample_count;
	} cfg_t;

	typedef struct packed {
		logic                    sample_valid;
		logic signed [ALT_W-1:0] altitude_dm;
		logic [TIME_W-1:0]       now_ms;
		logic                    gps_fix;
		logic                    storage_ok;
	} sample_t;

	typedef struct packed {
		logic [FLAGS_W-1:0]      status_flags;
		logic signed [ALT_W-1:0] max_altitude_dm;
		logic                    apogee_valid;
		logic signed [ALT_W-1:0] apogee_altitude_dm;
	} result_t;

endpackage

// ===== src/fed_ifs.sv =====
// Channel interfaces: sample input, status result, configuration write.
interface fed_sample_if;
	import fed_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    sample_valid;
	logic signed [ALT_W-1:0] altitude_dm;
	logic [TIME_W-1:0]       now_ms;
	logic                    gps_fix;
	logic                    storage_ok;

	modport source (output valid, sample_valid, altitude_dm, now_ms, gps_fix, storage_ok,
		input ready);
	modport sink (input valid, sample_valid, altitude_dm, now_ms, gps_fix, storage_ok,
		output ready);
endinterface

interface fed_result_if;
	import fed_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [FLAGS_W-1:0]      status_flags;
	logic signed [ALT_W-1:0] max_altitude_dm;
	logic                    apogee_valid;
	logic signed [ALT_W-1:0] apogee_altitude_dm;

	modport source (output valid, status_flags, max_altitude_dm, apogee_valid,
		apogee_altitude_dm, input ready);
	modport sink (input valid, status_flags, max_altitude_dm, apogee_valid,
		apogee_altitude_dm, output ready);
endinterface

interface fed_cfg_if;
	import fed_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fed_cfg_regs.sv =====
// Configuration register file.
module fed_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	fed_cfg_if.sink       cfg,
	output fed_pkg::cfg_t regs
);
	import fed_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.launch_gain_dm        <= RST_LAUNCH_GAIN;
			regs_q.confirm_runs          <= RST_LAUNCH_CONFIRM;
			regs_q.apogee_drop_dm        <= RST_APOGEE_DROP;
			regs_q.stale_timeout_ms      <= RST_STALE_TIMEOUT;
			regs_q.baseline_sample_count <= RST_BASELINE_COUNT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LAUNCH_GAIN:    regs_q.launch_gain_dm        <= cfg.data;
				CFG_LAUNCH_CONFIRM: regs_q.confirm_runs          <= cfg.data[COUNT_W-1:0];
				CFG_APOGEE_DROP:    regs_q.apogee_drop_dm        <= cfg.data;
				CFG_STALE_TIMEOUT:  regs_q.stale_timeout_ms      <= cfg.data;
				CFG_BASELINE_COUNT: regs_q.baseline_sample_count <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/fed_tracker.sv =====
// Flight state: baseline, maximum, launch and apogee detection, stale check.
module fed_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  fed_pkg::cfg_t    cfg,
	input  fed_pkg::sample_t smp,
	output fed_pkg::result_t result
);
	import fed_pkg::*;

	logic [COUNT_W-1:0]      seen_q, seen_d;
	logic signed [ALT_W-1:0] base_q, base_d;
	logic signed [ALT_W-1:0] max_q, max_d;
	logic [COUNT_W-1:0]      run_q, run_d;
	logic                    launched_q, launched_d;
	logic                    apogee_q, apogee_d;
	logic signed [ALT_W-1:0] apogee_alt_q, apogee_alt_d;
	logic [TIME_W-1:0]       last_q, last_d;

	logic signed [ALT_W-1:0] alt;
	logic                    capture;
	logic signed [ALT_W:0]   gain;
	logic signed [ALT_W:0]   drop;
	logic                    gain_hit;
	logic                    drop_hit;
	logic                    apogee_set;
	logic [TIME_W-1:0]       elapsed;
	logic                    stale;

	always_comb begin
		alt     = smp.sample_valid ? smp.altitude_dm : '0;
		capture = smp.sample_valid && (seen_q < cfg.baseline_sample_count);
		seen_d  = capture ? seen_q + COUNT_W'(1) : seen_q;
		base_d  = capture ? alt : base_q;
		max_d   = (smp.sample_valid && (alt > max_q)) ? alt : max_q;
		last_d  = smp.sample_valid ? smp.now_ms : last_q;

		gain     = {alt[ALT_W-1], alt} - {base_d[ALT_W-1], base_d};
		gain_hit = gain > $signed({{(ALT_W+1-MARGIN_W){1'b0}}, cfg.launch_gain_dm});
		run_d    = run_q;
		if (!launched_q) begin
			if (gain_hit)
				run_d = (run_q == '1) ? run_q : run_q + COUNT_W'(1);
			else
				run_d = '0;
		end
		launched_d = launched_q || (run_d >= cfg.confirm_runs);

		// apogee may latch on the same sample that declares launch
		drop       = {max_d[ALT_W-1], max_d} - {alt[ALT_W-1], alt};
		drop_hit   = drop > $signed({{(ALT_W+1-MARGIN_W){1'b0}}, cfg.apogee_drop_dm});
		apogee_set = launched_d && !apogee_q && drop_hit;
		apogee_d   = apogee_q || apogee_set;
		apogee_alt_d = apogee_set ? max_d : apogee_alt_q;

		elapsed = smp.now_ms - last_d;
		stale   = elapsed > {{(TIME_W-MARGIN_W){1'b0}}, cfg.stale_timeout_ms};

		result.status_flags              = '0;
		result.status_flags[BIT_LAUNCH]  = launched_d;
		result.status_flags[BIT_APOGEE]  = apogee_d;
		result.status_flags[BIT_GPS]     = smp.gps_fix;
		result.status_flags[BIT_BARO]    = smp.sample_valid;
		result.status_flags[BIT_STORAGE] = smp.storage_ok;
		result.status_flags[BIT_STALE]   = stale;
		result.max_altitude_dm    = max_d;
		result.apogee_valid       = apogee_d;
		result.apogee_altitude_dm = apogee_alt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			base_q       <= '0;
			max_q        <= '0;
			run_q        <= '0;
			launched_q   <= 1'b0;
			apogee_q     <= 1'b0;
			apogee_alt_q <= '0;
			last_q       <= '0;
		end else if (step) begin
			seen_q       <= seen_d;
			base_q       <= base_d;
			max_q        <= max_d;
			run_q        <= run_d;
			launched_q   <= launched_d;
			apogee_q     <= apogee_d;
			apogee_alt_q <= apogee_alt_d;
			last_q       <= last_d;
		end
	end

	a_apogee_after_launch: assert property (@(posedge clk) disable iff (!arst_n)
		apogee_q |-> launched_q)
		else $error("apogee latched without launch");

	a_launch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		launched_q |=> launched_q)
		else $error("launch flag cleared");

	a_apogee_alt_held: assert property (@(posedge clk) disable iff (!arst_n)
		apogee_q |=> apogee_q && $stable(apogee_alt_q))
		else $error("apogee altitude changed after latch");

endmodule

// ===== src/flight_event_detector.sv =====
// Top level of the flight event detector: sample register, tracker, result register.
// Usage:
//   sample: one word per altitude sample (validity bit, altitude in dm, ms timestamp,
//           GPS-fix and storage-ok bits), valid/ready handshake.
//   status: one word per sample (status flags, maximum altitude, apogee valid and
//           apogee altitude), valid/ready handshake, in sample order.
//   cfg:    register writes (index, data), always ready; write only while no word
//           is in flight.
// Path: the sample register holds a sample, the result register its status word.
// Throughput: one sample per cycle while status.ready is high; the state update is one
// pass of compares and adds between the sample register and the result register.
// Stall: when the status receiver holds ready low, the result register keeps its
// word and the sample register still takes one more word; after that sample.ready
// drops until the result moves on. No word is lost or repeated.
// Reset: arst_n clears the flight state, the pipeline and the configuration
// registers to their defaults; sample.ready is high out of reset.
module flight_event_detector (
	input logic          clk,
	input logic          arst_n,
	fed_sample_if.sink   sample,
	fed_result_if.source status,
	fed_cfg_if.sink      cfg
);
	import fed_pkg::*;

	cfg_t    cfg_regs;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;

	fed_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	assign adv_s1       = valid_s1 && (!valid_s2 || status.ready);
	assign sample.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample.ready)
			valid_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1.sample_valid <= sample.sample_valid;
			smp_s1.altitude_dm  <= sample.altitude_dm;
			smp_s1.now_ms       <= sample.now_ms;
			smp_s1.gps_fix      <= sample.gps_fix;
			smp_s1.storage_ok   <= sample.storage_ok;
		end
	end

	fed_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.cfg    (cfg_regs),
		.smp    (smp_s1),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || status.ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_next;
	end

	assign status.valid              = valid_s2;
	assign status.status_flags       = res_s2.status_flags;
	assign status.max_altitude_dm    = res_s2.max_altitude_dm;
	assign status.apogee_valid       = res_s2.apogee_valid;
	assign status.apogee_altitude_dm = res_s2.apogee_altitude_dm;

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result word without a sample");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !status.ready) |-> !sample.ready)
		else $error("sample register overwritten while stalled");

	a_step_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("processed sample did not reach the result register");

endmodule
